/* rtl/core/rcse_pkg.sv */
// Shared constants and types of the raster contour segment extractor.
// Depends on nothing; the interface, divider and top-level files refer to it by scoped names.
package rcse_pkg;

   localparam int SAMPLE_W   = 16;  // pixel samples and the level
   localparam int DIFF_W     = 17;  // difference of two samples
   localparam int MAG_W      = 16;  // magnitude of such a difference
   localparam int FRAC_W     = 8;   // Q.8 fraction bits
   localparam int DIV_STEPS  = MAG_W + FRAC_W;
   localparam int QUO_W      = DIV_STEPS + 1;
   localparam int COORD_W    = 20;
   localparam int DELTA_W    = 11;
   localparam int IMG_W_W    = 11;
   localparam int IMG_H_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEVEL  = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                     start;
      logic signed [DIFF_W-1:0] num;
      logic signed [DIFF_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [QUO_W-1:0] quo;
   } div_rsp_type;

endpackage

/* rtl/core/rcse_if.sv */
// Valid/ready channel interfaces of the contour extractor: pixel requests and segment responses.
// Depends on rcse_pkg for the field widths.
interface rcse_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [rcse_pkg::SAMPLE_W-1:0]  sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface rcse_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [rcse_pkg::COORD_W-1:0]   start_x;
   logic signed [rcse_pkg::COORD_W-1:0]   start_y;
   logic signed [rcse_pkg::DELTA_W-1:0]   delta_x;
   logic signed [rcse_pkg::DELTA_W-1:0]   delta_y;
   logic                                  last_of_pixel;
   modport source (output valid, output start_x, output start_y, output delta_x,
                   output delta_y, output last_of_pixel, input ready);
   modport sink   (input valid, input start_x, input start_y, input delta_x,
                   input delta_y, input last_of_pixel, output ready);
endinterface

/* rtl/core/rcse_row_mem.sv */
// Line buffer holding the previous row of samples, one write and one registered read port.
// Depends on nothing but its parameters.
module rcse_row_mem #(
   parameter int DEPTH = 1024,
   parameter int DW    = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DW-1:0]            wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DW-1:0]            rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/rcse_div.sv */
// Bit-serial signed divider computing trunc(num * 256 / den), zero when den is zero.
// Depends on rcse_pkg for widths and the request and response structs.
module rcse_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rcse_pkg::div_req_type div_req,
   output rcse_pkg::div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(rcse_pkg::DIV_STEPS);

   logic                              busy_ff, done_ff, neg_ff, zero_ff;
   logic [CNT_W-1:0]                  cnt_ff;
   logic [rcse_pkg::MAG_W-1:0]        rem_ff, den_ff;
   logic [rcse_pkg::DIV_STEPS-1:0]    dvd_ff;
   logic [rcse_pkg::DIFF_W-1:0]       num_abs, den_abs;
   logic [rcse_pkg::MAG_W:0]          part;
   logic                              ge;
   logic [rcse_pkg::MAG_W-1:0]        rem_in;
   logic signed [rcse_pkg::QUO_W-1:0] mag;

   assign num_abs = div_req.num[rcse_pkg::DIFF_W-1] ? -div_req.num : div_req.num;
   assign den_abs = div_req.den[rcse_pkg::DIFF_W-1] ? -div_req.den : div_req.den;

   assign part   = {rem_ff, dvd_ff[rcse_pkg::DIV_STEPS-1]};
   assign ge     = part >= {1'b0, den_ff};
   assign rem_in = ge ? rcse_pkg::MAG_W'(part - {1'b0, den_ff})
                      : part[rcse_pkg::MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(rcse_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff  <= '0;
         dvd_ff  <= {num_abs[rcse_pkg::MAG_W-1:0], {rcse_pkg::FRAC_W{1'b0}}};
         den_ff  <= den_abs[rcse_pkg::MAG_W-1:0];
         neg_ff  <= div_req.num[rcse_pkg::DIFF_W-1] ^ div_req.den[rcse_pkg::DIFF_W-1];
         zero_ff <= (div_req.den == '0);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[rcse_pkg::DIV_STEPS-2:0], ge};
      end
   end

   assign mag          = $signed({1'b0, dvd_ff});
   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = zero_ff ? '0 : (neg_ff ? -mag : mag);

endmodule

/* rtl/core/raster_contour_segment_extractor.sv */
// Top level of the raster contour segment extractor: control sequencer, registers, outputs.
// Depends on rcse_pkg, rcse_if, rcse_row_mem and rcse_div.
//
//   channel   direction  beat contents                                       handshake
//   req_bus   in         sample (signed 16)                                  valid/ready
//   rsp_bus   out        start_x, start_y, delta_x, delta_y, last_of_pixel   valid/ready
//   csr_*     in         csr_index, csr_wr_data                              csr_wr_en
//
// One pixel is worked on at a time. Accepting it reads the line buffer; the next
// cycle classifies the cell and border stubs and updates the row state, and a pixel
// with no segment then returns to idle. Each segment takes one or two divider passes,
// each an issue state and a wait state over the 24 shift steps, followed by a build
// state and a send state. Reset is synchronous; the line buffer is not cleared.
// A stalled response beat holds in the output register until taken and delays
// everything behind it.
module raster_contour_segment_extractor #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rcse_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rcse_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   rcse_req_if.sink                            req_bus,
   rcse_rsp_if.source                          rsp_bus
);

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int WC_W  = (WW > rcse_pkg::IMG_W_W) ? WW : rcse_pkg::IMG_W_W;
   localparam int CW    = 28;  // working width of coordinate sums
   localparam int SW    = rcse_pkg::SAMPLE_W;
   localparam int HW    = rcse_pkg::IMG_H_W;

   // Kinds of segment a pixel may produce: the six cell cases and four border stubs.
   typedef enum logic [3:0] {
      K_LL, K_UL, K_LR, K_UR, K_HZ, K_VT, K_BOT, K_TOP, K_LEFT, K_RIGHT
   } kind_type;

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_ISSUE1, S_WAIT1, S_ISSUE2, S_WAIT2, S_BUILD, S_SEND
   } state_type;

   // Configuration registers.
   logic signed [SW-1:0]             level_ff;
   logic [rcse_pkg::IMG_W_W-1:0]     img_w_ff;
   logic [HW-1:0]                    img_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         img_w_ff <= rcse_pkg::IMG_W_W'(1024);
         img_h_ff <= HW'(1024);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rcse_pkg::CSR_LEVEL:  level_ff <= $signed(csr_wr_data[SW-1:0]);
            rcse_pkg::CSR_WIDTH:  img_w_ff <= csr_wr_data[rcse_pkg::IMG_W_W-1:0];
            rcse_pkg::CSR_HEIGHT: img_h_ff <= csr_wr_data[HW-1:0];
            default: ;
         endcase
      end
   end

   // Effective frame size: width clamped to 2..MAX_WIDTH, height at least 2.
   logic [WC_W-1:0] w_raw, w_eff;
   logic [HW-1:0]   h_eff;
   assign w_raw = WC_W'(img_w_ff);
   assign w_eff = (w_raw < WC_W'(2)) ? WC_W'(2)
                : ((w_raw > WC_W'(MAX_WIDTH)) ? WC_W'(MAX_WIDTH) : w_raw);
   assign h_eff = (img_h_ff < HW'(2)) ? HW'(2) : img_h_ff;

   state_type state_ff, state_in;

   logic               accept;
   logic signed [SW-1:0] sample_ff;
   logic signed [SW-1:0] left_ff, ul_ff;
   logic [AW-1:0]      col_ff;
   logic [HW-1:0]      row_ff;
   logic signed [SW-1:0] row_rd;
   logic [SW-1:0]      row_rd_raw;

   assign accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   rcse_row_mem #(.DEPTH(MAX_WIDTH), .DW(SW)) u_row_mem (
      .clock   (clock),
      .wr_en   (state_ff == S_LOAD),
      .wr_addr (col_ff),
      .wr_data (sample_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (row_rd_raw)
   );
   assign row_rd = $signed(row_rd_raw);

   // Cell classification and border stubs, evaluated in the load cycle on the
   // corners v00 = upper left, v01 = above, v10 = left, v11 = new sample.
   logic       p00, p01, p10, p11, e01, e11;
   logic       cell_on, c_pos, r_pos;
   logic       st_lf, st_up;
   kind_type   kind_in [4];
   logic [2:0] cnt_in;

   function automatic logic above(input logic signed [SW-1:0] v,
                                  input logic signed [SW-1:0] l);
      return v > l;
   endfunction

   always_comb begin
      p00 = ul_ff < level_ff;
      p01 = row_rd < level_ff;
      p10 = left_ff < level_ff;
      p11 = sample_ff < level_ff;
      e01 = (p01 == p00);
      e11 = (p11 == p00);
      c_pos = (col_ff != '0);
      r_pos = (row_ff != '0);
      cell_on = c_pos && r_pos;
      st_lf = above(left_ff, level_ff) != above(sample_ff, level_ff);
      st_up = above(row_rd, level_ff) != above(sample_ff, level_ff);
      for (int k = 0; k < 4; k++) begin
         kind_in[k] = K_LL;
      end
      cnt_in = '0;
      if (cell_on) begin
         if (p00 != p10) begin
            if (!e01 && !e11) begin
               kind_in[0] = K_LL; cnt_in = 3'd1;
            end else if (e01 && !e11) begin
               kind_in[0] = K_HZ; cnt_in = 3'd1;
            end else if (e01 && e11) begin
               kind_in[0] = K_UL; cnt_in = 3'd1;
            end else if (p00) begin
               kind_in[0] = K_LL; kind_in[1] = K_UR; cnt_in = 3'd2;
            end else begin
               kind_in[0] = K_UL; kind_in[1] = K_LR; cnt_in = 3'd2;
            end
         end else begin
            if (!e01 && e11) begin
               kind_in[0] = K_LR; cnt_in = 3'd1;
            end else if (e01 && !e11) begin
               kind_in[0] = K_UR; cnt_in = 3'd1;
            end else if (!e01 && !e11) begin
               kind_in[0] = K_VT; cnt_in = 3'd1;
            end
         end
      end
      // Bottom stub on the first row, top stub on the last one.
      if (c_pos && st_lf) begin
         if (!r_pos) begin
            kind_in[cnt_in[1:0]] = K_BOT; cnt_in = cnt_in + 3'd1;
         end else if (row_ff == h_eff - HW'(1)) begin
            kind_in[cnt_in[1:0]] = K_TOP; cnt_in = cnt_in + 3'd1;
         end
      end
      // Left stub comes alone from the first pixel of a row.
      if (!c_pos && r_pos && st_up) begin
         kind_in[cnt_in[1:0]] = K_LEFT; cnt_in = cnt_in + 3'd1;
      end
      if (c_pos && (WC_W'(col_ff) == w_eff - WC_W'(1)) && r_pos && st_up) begin
         kind_in[cnt_in[1:0]] = K_RIGHT; cnt_in = cnt_in + 3'd1;
      end
   end

   // Per-pixel registers filled in the load cycle; the quotients are filled in the wait states.
   kind_type             kind_ff [4];
   logic [2:0]           cnt_ff;
   logic [1:0]           slot_ff;
   logic signed [SW-1:0] v00_ff, v01_ff, v10_ff, v11_ff;
   logic [AW-1:0]        pix_c_ff;
   logic [HW-1:0]        pix_r_ff;
   logic signed [rcse_pkg::QUO_W-1:0] q1_ff, q2_ff;

   kind_type cur_kind;
   logic     two_quo, last_slot;
   assign cur_kind  = kind_ff[slot_ff];
   assign two_quo   = (cur_kind == K_LL) || (cur_kind == K_UL) || (cur_kind == K_LR) ||
                      (cur_kind == K_UR) || (cur_kind == K_HZ) || (cur_kind == K_VT);
   assign last_slot = ({1'b0, slot_ff} + 3'd1) == cnt_ff;

   // Divider operand selection.
   rcse_pkg::div_req_type div_req;
   rcse_pkg::div_rsp_type div_rsp;

   function automatic logic signed [rcse_pkg::DIFF_W-1:0] sub(
      input logic signed [SW-1:0] a, input logic signed [SW-1:0] b);
      return $signed({a[SW-1], a}) - $signed({b[SW-1], b});
   endfunction

   logic signed [rcse_pkg::DIFF_W-1:0] d00, d01, d10, d11;
   assign d00 = sub(level_ff, v00_ff);
   assign d01 = sub(level_ff, v01_ff);
   assign d10 = sub(level_ff, v10_ff);
   assign d11 = sub(level_ff, v11_ff);

   always_comb begin
      div_req.start = (state_ff == S_ISSUE1) || (state_ff == S_ISSUE2);
      div_req.num   = d00;
      div_req.den   = sub(v01_ff, v00_ff);
      if (state_ff == S_ISSUE2) begin
         case (cur_kind)
            K_LL: begin div_req.num = d00; div_req.den = sub(v10_ff, v00_ff); end
            K_UL, K_VT: begin div_req.num = d10; div_req.den = sub(v11_ff, v10_ff); end
            K_UR: begin div_req.num = d11; div_req.den = sub(v01_ff, v11_ff); end
            default: begin div_req.num = d01; div_req.den = sub(v11_ff, v01_ff); end
         endcase
      end else begin
         case (cur_kind)
            K_UL, K_HZ: begin div_req.num = d00; div_req.den = sub(v10_ff, v00_ff); end
            K_UR: begin div_req.num = d10; div_req.den = sub(v11_ff, v10_ff); end
            K_BOT, K_TOP: begin div_req.num = d11; div_req.den = sub(v11_ff, v10_ff); end
            K_LEFT, K_RIGHT: begin
               div_req.num = d11; div_req.den = sub(v11_ff, v01_ff);
            end
            default: begin div_req.num = d00; div_req.den = sub(v01_ff, v00_ff); end
         endcase
      end
   end

   rcse_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Segment assembly from the two quotients, then saturation.
   logic signed [CW-1:0] q1, q2, ci, rj, x_w, y_w, dx_w, dy_w;
   localparam logic signed [CW-1:0] HALF = CW'(128);
   localparam logic signed [CW-1:0] ONE  = CW'(256);

   always_comb begin
      q1 = CW'(q1_ff);
      q2 = CW'(q2_ff);
      ci = $signed({{(CW - AW - rcse_pkg::FRAC_W){1'b0}}, pix_c_ff, {rcse_pkg::FRAC_W{1'b0}}});
      rj = $signed({{(CW - HW - rcse_pkg::FRAC_W){1'b0}}, pix_r_ff, {rcse_pkg::FRAC_W{1'b0}}});
      x_w = ci - HALF; y_w = rj - HALF; dx_w = '0; dy_w = '0;
      case (cur_kind)
         K_LL: begin y_w = rj + q2 - HALF; dx_w = q1; dy_w = -q2; end
         K_UL: begin y_w = rj + q1 - HALF; dx_w = q2; dy_w = ONE - q1; end
         K_LR: begin x_w = ci + q1 - HALF; dx_w = ONE - q1; dy_w = q2; end
         K_UR: begin
            x_w = ci + q1 - HALF; y_w = rj + HALF; dx_w = ONE - q1; dy_w = -q2;
         end
         K_HZ: begin y_w = rj + q1 - HALF; dx_w = ONE; dy_w = q2 - q1; end
         K_VT: begin x_w = ci + q1 - HALF; dx_w = q2 - q1; dy_w = ONE; end
         K_BOT: begin x_w = ci + q1; y_w = '0; dy_w = -HALF; end
         K_TOP: begin x_w = ci + q1; y_w = rj; dy_w = HALF; end
         K_LEFT: begin x_w = '0; y_w = rj + q1; dx_w = -HALF; end
         default: begin x_w = ci; y_w = rj + q1; dx_w = HALF; end
      endcase
   end

   function automatic logic signed [rcse_pkg::COORD_W-1:0] sat_c(input logic signed [CW-1:0] v);
      localparam logic signed [CW-1:0] HI = CW'((1 << (rcse_pkg::COORD_W - 1)) - 1);
      if (v > HI) return {1'b0, {(rcse_pkg::COORD_W - 1){1'b1}}};
      if (v < -HI - CW'(1)) return {1'b1, {(rcse_pkg::COORD_W - 1){1'b0}}};
      return v[rcse_pkg::COORD_W-1:0];
   endfunction

   function automatic logic signed [rcse_pkg::DELTA_W-1:0] sat_d(input logic signed [CW-1:0] v);
      localparam logic signed [CW-1:0] HI = CW'((1 << (rcse_pkg::DELTA_W - 1)) - 1);
      if (v > HI) return {1'b0, {(rcse_pkg::DELTA_W - 1){1'b1}}};
      if (v < -HI - CW'(1)) return {1'b1, {(rcse_pkg::DELTA_W - 1){1'b0}}};
      return v[rcse_pkg::DELTA_W-1:0];
   endfunction

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_LOAD;
         S_LOAD:   state_in = (cnt_in == '0) ? S_IDLE : S_ISSUE1;
         S_ISSUE1: state_in = S_WAIT1;
         S_WAIT1:  if (div_rsp.done) state_in = two_quo ? S_ISSUE2 : S_BUILD;
         S_ISSUE2: state_in = S_WAIT2;
         S_WAIT2:  if (div_rsp.done) state_in = S_BUILD;
         S_BUILD:  state_in = S_SEND;
         S_SEND:   if (rsp_bus.ready) state_in = last_slot ? S_IDLE : S_ISSUE1;
         default:  state_in = S_IDLE;
      endcase
   end

   logic rsp_valid_ff, last_ff;
   logic signed [rcse_pkg::COORD_W-1:0] sx_ff, sy_ff;
   logic signed [rcse_pkg::DELTA_W-1:0] dx_ff, dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
         ul_ff        <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         slot_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_LOAD) begin
            ul_ff   <= row_rd;
            left_ff <= sample_ff;
            cnt_ff  <= cnt_in;
            slot_ff <= '0;
            if (WC_W'(col_ff) + WC_W'(1) >= w_eff) begin
               col_ff <= '0;
               row_ff <= ({1'b0, row_ff} + 17'd1 >= {1'b0, h_eff}) ? '0 : row_ff + HW'(1);
            end else begin
               col_ff <= col_ff + AW'(1);
            end
         end
         if (state_ff == S_BUILD) begin
            rsp_valid_ff <= 1'b1;
         end
         if (state_ff == S_SEND && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
            slot_ff      <= slot_ff + 2'd1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_bus.sample;
      end
      if (state_ff == S_LOAD) begin
         v00_ff   <= ul_ff;
         v01_ff   <= row_rd;
         v10_ff   <= left_ff;
         v11_ff   <= sample_ff;
         pix_c_ff <= col_ff;
         pix_r_ff <= row_ff;
         for (int k = 0; k < 4; k++) begin
            kind_ff[k] <= kind_in[k];
         end
      end
      if (state_ff == S_WAIT1 && div_rsp.done) begin
         q1_ff <= div_rsp.quo;
         q2_ff <= '0;
      end
      if (state_ff == S_WAIT2 && div_rsp.done) begin
         q2_ff <= div_rsp.quo;
      end
      if (state_ff == S_BUILD) begin
         sx_ff   <= sat_c(x_w);
         sy_ff   <= sat_c(y_w);
         dx_ff   <= sat_d(dx_w);
         dy_ff   <= sat_d(dy_w);
         last_ff <= last_slot;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.start_x       = sx_ff;
   assign rsp_bus.start_y       = sy_ff;
   assign rsp_bus.delta_x       = dx_ff;
   assign rsp_bus.delta_y       = dy_ff;
   assign rsp_bus.last_of_pixel = last_ff;

   // A response beat is only ever offered from the send state.
   a_valid_in_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_SEND)
      else $error("response valid outside send state");

   // A new pixel is never taken while a segment beat is still pending.
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !rsp_valid_ff)
      else $error("pixel accepted with a pending segment");

   // The slot being worked on stays inside the planned list.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEND) |-> ({1'b0, slot_ff} < cnt_ff))
      else $error("segment slot beyond planned count");

   // The divider finishes only while the sequencer waits for it.
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_WAIT1 || state_ff == S_WAIT2))
      else $error("divider result arrived unexpectedly");

endmodule
